// ===== rtl/bbhcrc_pkg.sv =====
// Shared types and constants for the baseband header builder.
// Holds the configuration record, the header result record and the CRC-8 column table.
// No dependencies.
package bbhcrc_pkg;

	localparam int HEADER_CRC_BITS = 72;
	localparam logic [7:0] CRC8_POLY = 8'hAB;
	localparam logic [15:0] TS_PACKET_BYTES = 16'd188;
	localparam logic [15:0] NIBBLE_OFFSET = 16'd4;
	localparam logic [1:0] ROLLOFF_MARKER = 2'b11;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_STREAM_TYPE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FLAGS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ROLLOFF_CODE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_S2X_ALTERNATE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INPUT_STREAM_ID = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_USER_PACKET_LEN = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_DATA_FIELD_LEN = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE = 3'd7;

	typedef struct packed {
		logic [1:0]  stream_type;
		logic [3:0]  header_flags;
		logic [1:0]  rolloff_code;
		logic        s2x_alternate;
		logic [7:0]  input_stream_id;
		logic [15:0] user_packet_length;
		logic [15:0] data_field_length;
		logic [7:0]  sync_byte;
	} cfg_t;

	typedef struct packed {
		logic [15:0] matype;
		logic [15:0] upl;
		logic [15:0] dfl;
		logic [7:0]  sync;
		logic [15:0] syncd;
		logic [7:0]  crc;
	} hdr_t;

	typedef logic [HEADER_CRC_BITS-1:0][7:0] crc_cols_t;

	// Column p is the CRC contribution of a one at header bit p (bit 0 is sent last).
	// The CRC starts at zero, so the full CRC is the XOR of the columns of the set bits.
	function automatic crc_cols_t crc_columns();
		crc_cols_t  cols;
		logic [7:0] c;
		c = CRC8_POLY;
		for (int p = 0; p < HEADER_CRC_BITS; p++) begin
			cols[p] = c;
			c = (c >> 1) ^ (c[0] ? CRC8_POLY : 8'h00);
		end
		return cols;
	endfunction

	localparam crc_cols_t CRC_COLS = crc_columns();

endpackage

// ===== rtl/bbhcrc_fields.sv =====
// Header field assembly and parallel CRC-8 for one request.
// Purely combinational; uses cfg_t, hdr_t and the CRC column table from bbhcrc_pkg.
module bbhcrc_fields (
	input  bbhcrc_pkg::cfg_t cfg,
	input  logic [1:0]       rolloff,
	input  logic [15:0]      padding_bits,
	input  logic [7:0]       packet_count,
	input  logic             nibble_aligned,
	output bbhcrc_pkg::hdr_t hdr
);

	logic [7:0]  mat1;
	logic [7:0]  isi;
	logic [15:0] syncd_base;
	logic [15:0] syncd;
	logic [15:0] dfl;
	logic [bbhcrc_pkg::HEADER_CRC_BITS-1:0] crc_bits;
	logic [7:0]  crc;

	assign mat1 = {cfg.stream_type, cfg.header_flags, rolloff};
	// Single stream mode blanks the ISI byte.
	assign isi = cfg.header_flags[3] ? 8'h00 : cfg.input_stream_id;
	assign dfl = cfg.data_field_length - padding_bits;

	always_comb begin
		if (packet_count == 8'd0) begin
			syncd_base = 16'd0;
		end else begin
			syncd_base = (bbhcrc_pkg::TS_PACKET_BYTES - {8'd0, packet_count}) << 3;
		end
		syncd = nibble_aligned ? syncd_base : syncd_base + bbhcrc_pkg::NIBBLE_OFFSET;
	end

	// The first 72 header bits, first transmitted bit at the top.
	assign crc_bits = {mat1, isi, cfg.user_packet_length, dfl, cfg.sync_byte, syncd};

	always_comb begin
		crc = 8'h00;
		for (int p = 0; p < bbhcrc_pkg::HEADER_CRC_BITS; p++) begin
			crc = crc ^ (crc_bits[p] ? bbhcrc_pkg::CRC_COLS[p] : 8'h00);
		end
	end

	always_comb begin
		hdr.matype = {mat1, isi};
		hdr.upl = cfg.user_packet_length;
		hdr.dfl = dfl;
		hdr.sync = cfg.sync_byte;
		hdr.syncd = syncd;
		// Register bit 0 goes out first, so it lands in the MSB.
		for (int n = 0; n < 8; n++) begin
			hdr.crc[7-n] = crc[n];
		end
	end

endmodule

// ===== rtl/baseband_header_crc8_builder.sv =====
// Top level of the baseband header builder with CRC-8.
// Depends on bbhcrc_pkg and bbhcrc_fields.
//
// Usage:
//   The request channel (req_valid, req_stall) carries padding_bits, packet_count and
//   nibble_aligned. A transaction takes place at a rising edge with req_valid high
//   and req_stall low. Each request yields exactly one header on the result channel
//   (hdr_valid, hdr_stall), which completes at an edge with hdr_valid high and
//   hdr_stall low.
//   The request is registered, the fields and the 72-bit parallel CRC are formed in
//   one pass, and the header is registered. Throughput is one header per cycle while
//   the receiver does not stall.
//   When the receiver stalls, the header register holds, the request register fills,
//   and then req_stall rises until the header is taken.
//   Configuration writes go through cfg_valid, cfg_ready (always high), cfg_index and
//   cfg_data. The user must make writes only while no request is in flight; the block
//   does not enforce it. Reset empties both registers, loads the defaults (stream type
//   1, single stream flag set) and arms the S2X rolloff marker for the next header.
module baseband_header_crc8_builder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bbhcrc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bbhcrc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [15:0]                        padding_bits,
	input  logic [7:0]                         packet_count,
	input  logic                               nibble_aligned,
	output logic                               hdr_valid,
	input  logic                               hdr_stall,
	output logic [15:0]                        matype,
	output logic [15:0]                        upl_out,
	output logic [15:0]                        dfl_out,
	output logic [7:0]                         sync_out,
	output logic [15:0]                        syncd_out,
	output logic [7:0]                         crc_byte
);

	bbhcrc_pkg::cfg_t cfg_q;
	logic             marker_phase_q;

	logic             valid_s1;
	logic [15:0]      padding_s1;
	logic [7:0]       count_s1;
	logic             aligned_s1;
	logic [1:0]       rolloff_s1;

	logic             valid_s2;
	bbhcrc_pkg::hdr_t hdr_s2;
	bbhcrc_pkg::hdr_t hdr_next;

	logic             req_take;
	logic             adv_s2;
	logic             adv_s1;
	logic [1:0]       rolloff_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stream_type <= 2'd1;
			cfg_q.header_flags <= 4'd8;
			cfg_q.rolloff_code <= 2'd0;
			cfg_q.s2x_alternate <= 1'b0;
			cfg_q.input_stream_id <= 8'd0;
			cfg_q.user_packet_length <= 16'd0;
			cfg_q.data_field_length <= 16'd0;
			cfg_q.sync_byte <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bbhcrc_pkg::REG_STREAM_TYPE: cfg_q.stream_type <= cfg_data[1:0];
				bbhcrc_pkg::REG_HEADER_FLAGS: cfg_q.header_flags <= cfg_data[3:0];
				bbhcrc_pkg::REG_ROLLOFF_CODE: cfg_q.rolloff_code <= cfg_data[1:0];
				bbhcrc_pkg::REG_S2X_ALTERNATE: cfg_q.s2x_alternate <= cfg_data[0];
				bbhcrc_pkg::REG_INPUT_STREAM_ID: cfg_q.input_stream_id <= cfg_data[7:0];
				bbhcrc_pkg::REG_USER_PACKET_LEN: cfg_q.user_packet_length <= cfg_data;
				bbhcrc_pkg::REG_DATA_FIELD_LEN: cfg_q.data_field_length <= cfg_data;
				bbhcrc_pkg::REG_SYNC_BYTE: cfg_q.sync_byte <= cfg_data[7:0];
			endcase
		end
	end

	// The output register moves when empty or taken; the request register moves into it.
	assign adv_s2 = !valid_s2 || !hdr_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign req_stall = !adv_s1;
	assign req_take = req_valid && adv_s1;

	// The rolloff is fixed in request order, so the marker phase steps at acceptance.
	assign rolloff_next = (cfg_q.s2x_alternate && marker_phase_q) ?
		bbhcrc_pkg::ROLLOFF_MARKER : cfg_q.rolloff_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_phase_q <= 1'b1;
		end else if (req_take && cfg_q.s2x_alternate) begin
			marker_phase_q <= !marker_phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			padding_s1 <= padding_bits;
			count_s1 <= packet_count;
			aligned_s1 <= nibble_aligned;
			rolloff_s1 <= rolloff_next;
		end
		if (adv_s2 && valid_s1) begin
			hdr_s2 <= hdr_next;
		end
	end

	bbhcrc_fields u_fields (
		.cfg            (cfg_q),
		.rolloff        (rolloff_s1),
		.padding_bits   (padding_s1),
		.packet_count   (count_s1),
		.nibble_aligned (aligned_s1),
		.hdr            (hdr_next)
	);

	assign hdr_valid = valid_s2;
	assign matype = hdr_s2.matype;
	assign upl_out = hdr_s2.upl;
	assign dfl_out = hdr_s2.dfl;
	assign sync_out = hdr_s2.sync;
	assign syncd_out = hdr_s2.syncd;
	assign crc_byte = hdr_s2.crc;

endmodule
